@@ rtl/swgq_pkg.sv @@
// ============================================================================
// swgq_pkg : shared types and constants for the sliding window gcd queue
// Word layouts, status codes, sequencer states and default sizes.
// ============================================================================
package swgq_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 63;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [62:0] value;
    } in_word_t;

    typedef struct packed {
        logic [62:0] window_gcd;
        logic [6:0]  occupancy;
        logic [1:0]  status;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_GCD,
        S_FLIP_RD,
        S_FLIP_GCD,
        S_FLIP_WR,
        S_POP,
        S_FOLD_RD,
        S_FOLD_GCD,
        S_RESULT
    } state_t;

endpackage

@@ rtl/swgq_gcd.sv @@
// ============================================================================
// swgq_gcd : iterative binary gcd unit
// Stein's algorithm, one subtract-and-shift step per cycle.
// ============================================================================
module swgq_gcd #(
    parameter int VALUE_BITS = swgq_pkg::DEF_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    output logic                  done,
    output logic [VALUE_BITS-1:0] result
);

    localparam int SW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] a_reg, a_next, b_reg, b_next;
    logic [SW-1:0]         k_reg, k_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS-1:0] res_reg, res_next;

    // one step: strip common twos, strip twos of each, subtract
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            k_next   = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (a_reg == '0 || b_reg == '0)
            begin
                res_next  = (a_reg | b_reg) << k_reg;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
                a_next = a_reg >> 1;
            else if (!b_reg[0])
                b_next = b_reg >> 1;
            else if (a_reg >= b_reg)
                a_next = (a_reg - b_reg) >> 1;
            else
                b_next = (b_reg - a_reg) >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ rtl/sliding_window_gcd_queue.sv @@
// ============================================================================
// sliding_window_gcd_queue : fifo window with running gcd
// Two stacks of (value, fold) held in synchronous memories; one gcd unit.
// ============================================================================
//  channel | ports                         | handshake
//  in      | start, busy, in_word          | taken when start && !busy
//  out     | out_valid, out_word           | one-cycle strobe, no stall
//
//  A push takes up to two gcd runs (new fold, then window fold). A pop
//  with a nonempty front stack takes at most one window gcd; a pop that
//  finds the front empty first moves every back entry, one read, a gcd
//  (but for the first entry) and one write each, so the cost is amortized
//  over the elements. Reset clears the counts, state and flags; memories
//  need no clear. The receiver cannot stall; busy stays high until the
//  result strobe.
module sliding_window_gcd_queue #(
    parameter int CAPACITY   = swgq_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = swgq_pkg::DEF_VALUE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  swgq_pkg::in_word_t  in_word,
    output logic                out_valid,
    output swgq_pkg::out_word_t out_word
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef logic [2*VALUE_BITS-1:0] entry_t;

    // memories: {value, fold}
    entry_t back_mem  [CAPACITY];
    entry_t front_mem [CAPACITY];

    swgq_pkg::state_t state_reg, state_next;
    logic [CW-1:0] bc_reg, bc_next, fc_reg, fc_next;
    logic [1:0]    status_reg, status_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;     // pushed or moved value
    logic [VALUE_BITS-1:0] gcd_reg, gcd_next;

    logic          back_we, front_we;
    logic [AW-1:0] back_wa, front_wa, back_ra, front_ra;
    entry_t        back_wd, front_wd, back_rd, front_rd;

    logic                  g_start, g_done;
    logic [VALUE_BITS-1:0] g_a, g_b, g_res;

    logic [VALUE_BITS-1:0] back_top, front_top;

    // flip mode: set on every pop, cleared on a push
    logic flip_mode, flip_reg, flip_next;
    logic fold_wait_reg, fold_wait_next;

    swgq_gcd #(.VALUE_BITS(VALUE_BITS)) u_gcd (
        .clk(clk), .rst_n(rst_n), .start(g_start),
        .a(g_a), .b(g_b), .done(g_done), .result(g_res)
    );

    // memory ports
    always_ff @(posedge clk)
    begin
        if (back_we)
            back_mem[back_wa] <= back_wd;
        back_rd <= back_mem[back_ra];
    end

    always_ff @(posedge clk)
    begin
        if (front_we)
            front_mem[front_wa] <= front_wd;
        front_rd <= front_mem[front_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swgq_pkg::S_IDLE;
            bc_reg    <= '0;
            fc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bc_reg    <= bc_next;
            fc_reg    <= fc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        v_reg      <= v_next;
        gcd_reg    <= gcd_next;
    end

    assign back_top  = back_rd[VALUE_BITS-1:0];
    assign front_top = front_rd[VALUE_BITS-1:0];

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        bc_next     = bc_reg;
        fc_next     = fc_reg;
        status_next = status_reg;
        v_next      = v_reg;
        gcd_next    = gcd_reg;
        back_ra     = bc_reg[AW-1:0] - 1'b1;
        front_ra    = fc_reg[AW-1:0] - 1'b1;
        g_start     = 1'b0;
        g_a         = '0;
        g_b         = '0;
        unique case (state_reg)
            swgq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    status_next = swgq_pkg::ST_DONE;
                    v_next      = in_word.value[VALUE_BITS-1:0];
                    if (in_word.func == swgq_pkg::FUNC_PUSH)
                    begin
                        if ({1'b0, bc_reg} + {1'b0, fc_reg} >= (CW+1)'(CAPACITY))
                        begin
                            status_next = swgq_pkg::ST_PUSH_FULL;
                            state_next  = swgq_pkg::S_FOLD_RD;
                        end
                        else if (bc_reg == '0)
                        begin
                            gcd_next   = in_word.value[VALUE_BITS-1:0];
                            state_next = swgq_pkg::S_PUSH_GCD;
                        end
                        else
                            state_next = swgq_pkg::S_PUSH_RD;
                    end
                    else if (bc_reg == '0 && fc_reg == '0)
                    begin
                        status_next = swgq_pkg::ST_POP_EMPTY;
                        state_next  = swgq_pkg::S_FOLD_RD;
                    end
                    else if (fc_reg == '0)
                        state_next = swgq_pkg::S_FLIP_RD;
                    else
                        state_next = swgq_pkg::S_POP;
                end
            end
            swgq_pkg::S_PUSH_RD:
            begin
                // back_rd holds top fold
                g_start    = 1'b1;
                g_a        = back_rd[VALUE_BITS-1:0];
                g_b        = v_reg;
                state_next = swgq_pkg::S_PUSH_GCD;
            end
            swgq_pkg::S_PUSH_GCD:
            begin
                // a bare push to an empty stack skips the unit
                if (bc_reg == '0 || g_done)
                begin
                    if (bc_reg != '0)
                        gcd_next = g_res;
                    state_next = swgq_pkg::S_FLIP_WR;
                end
            end
            swgq_pkg::S_FLIP_RD:
            begin
                // back_rd: top back entry now valid
                v_next = back_rd[2*VALUE_BITS-1:VALUE_BITS];
                if (fc_reg == '0)
                begin
                    gcd_next   = back_rd[2*VALUE_BITS-1:VALUE_BITS];
                    state_next = swgq_pkg::S_FLIP_WR;
                end
                else
                begin
                    // front top fold was just written and still sits in gcd_reg
                    g_start    = 1'b1;
                    g_a        = back_rd[2*VALUE_BITS-1:VALUE_BITS];
                    g_b        = gcd_reg;
                    state_next = swgq_pkg::S_FLIP_GCD;
                end
            end
            swgq_pkg::S_FLIP_GCD:
            begin
                if (g_done)
                begin
                    gcd_next   = g_res;
                    state_next = swgq_pkg::S_FLIP_WR;
                end
            end
            swgq_pkg::S_FLIP_WR:
            begin
                if (flip_mode)
                begin
                    bc_next = bc_reg - 1'b1;
                    fc_next = fc_reg + 1'b1;
                    back_ra  = bc_reg[AW-1:0] - 2'd2;
                    front_ra = fc_reg[AW-1:0];
                    if (bc_reg == CW'(1))
                        state_next = swgq_pkg::S_POP;
                    else
                        state_next = swgq_pkg::S_FLIP_RD;
                end
                else
                begin
                    bc_next    = bc_reg + 1'b1;
                    state_next = swgq_pkg::S_FOLD_RD;
                end
            end
            swgq_pkg::S_POP:
            begin
                fc_next    = fc_reg - 1'b1;
                state_next = swgq_pkg::S_FOLD_RD;
            end
            swgq_pkg::S_FOLD_RD:
            begin
                // address presets above read both tops
                state_next = swgq_pkg::S_FOLD_GCD;
            end
            swgq_pkg::S_FOLD_GCD:
            begin
                if (fc_reg == '0 || bc_reg == '0)
                begin
                    gcd_next = (fc_reg == '0) ?
                        ((bc_reg == '0) ? '0 : back_top) : front_top;
                    state_next = swgq_pkg::S_RESULT;
                end
                else if (fold_wait_reg)
                begin
                    if (g_done)
                    begin
                        gcd_next   = g_res;
                        state_next = swgq_pkg::S_RESULT;
                    end
                end
                else
                begin
                    g_start = 1'b1;
                    g_a     = front_top;
                    g_b     = back_top;
                end
            end
            swgq_pkg::S_RESULT:
                state_next = swgq_pkg::S_IDLE;
            default:
                state_next = swgq_pkg::S_IDLE;
        endcase
    end

    assign flip_mode = flip_reg;

    always_comb
    begin
        flip_next      = flip_reg;
        fold_wait_next = 1'b0;
        if (state_reg == swgq_pkg::S_IDLE && start)
            flip_next = (in_word.func == swgq_pkg::FUNC_POP);
        if (state_reg == swgq_pkg::S_FOLD_GCD && fc_reg != '0 && bc_reg != '0 && !g_done)
            fold_wait_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg      <= 1'b0;
            fold_wait_reg <= 1'b0;
        end
        else
        begin
            flip_reg      <= flip_next;
            fold_wait_reg <= fold_wait_next;
        end
    end

    // memory writes: value and fold at the stack top
    always_comb
    begin
        back_we  = 1'b0;
        front_we = 1'b0;
        back_wa  = bc_reg[AW-1:0];
        front_wa = fc_reg[AW-1:0];
        back_wd  = {v_reg, gcd_reg};
        front_wd = {v_reg, gcd_reg};
        if (state_reg == swgq_pkg::S_FLIP_WR)
        begin
            if (flip_reg)
                front_we = 1'b1;
            else
                back_we = 1'b1;
        end
    end

    // outputs
    assign busy      = (state_reg != swgq_pkg::S_IDLE);
    assign out_valid = (state_reg == swgq_pkg::S_RESULT);
    always_comb
    begin
        out_word            = '0;
        out_word.window_gcd = 63'(gcd_reg);
        out_word.occupancy  = 7'({1'b0, bc_reg} + {1'b0, fc_reg});
        out_word.status     = status_reg;
    end

endmodule
